// File: hw/rtl/tdt_pkg.sv
// Shared types and constants of the triggered distance table unit.
package tdt_pkg;

  localparam int SLOT_W = 6;   // slot field width
  localparam int CNT_W  = 7;   // coord_count register width
  localparam int TRIG_W = 16;  // trigger field width
  localparam int CMP_W  = 9;   // holds any count up to the largest table (256)
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [CNT_W-1:0]  COUNT_RST  = 7'd64;
  localparam logic [APB_AW-1:0] ADDR_COUNT = 2'd0;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_CTRL = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic  wr_en;      // write the input coordinate into the table
    logic  loc_ld;     // capture the listener location
    logic  rd_en;      // read the table entry at the current index
    logic  acc_clr;    // clear the sum of squares
    logic  diff_en;    // register |location - coordinate| of one axis
    axis_t axis;
    logic  acc_en;     // add the square of the registered difference
    logic  root_init;  // start the square root
    logic  root_step;  // one digit of the square root
    logic  out_ld;     // load the result register
    logic  out_last;   // result closes the run
  } dp_cmd_t;

endpackage

// File: hw/rtl/tdt_ctrl.sv
// Sequencer of the triggered distance table unit: edge detect, slot walk, step counts.
module tdt_ctrl #(
  parameter int MAX_COORDS = 64,
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_action,
  input  logic [tdt_pkg::SLOT_W-1:0]  in_slot,
  input  logic [tdt_pkg::TRIG_W-1:0]  in_trigger,
  input  logic [tdt_pkg::CNT_W-1:0]   coord_count,
  input  logic                        out_hold,
  output logic                        in_stall,
  output logic [IDX_W-1:0]            idx,
  output tdt_pkg::dp_cmd_t            cmd
);
  import tdt_pkg::*;

  localparam int SQRT_STEPS = COORD_BITS + 1;
  localparam int STEP_W     = $clog2(SQRT_STEPS + 1);
  localparam logic [CMP_W-1:0]  MAX_EXT  = CMP_W'(MAX_COORDS);
  localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] RT_LAST  = STEP_W'(SQRT_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQ,
    S_ROOT,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    last_r;
  logic [STEP_W-1:0]   step_r;
  logic                prev_high_r;

  logic                accept;
  logic                is_ctrl;
  logic                trig_high;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    neff;
  logic                slot_ok;
  logic                start;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign is_ctrl   = (in_action == ACT_CTRL);
  assign trig_high = !in_trigger[TRIG_W-1] && (|in_trigger);
  assign cnt_ext   = CMP_W'(coord_count);
  assign neff      = (cnt_ext > MAX_EXT) ? MAX_EXT : cnt_ext;
  assign slot_ok   = (CMP_W'(in_slot) < MAX_EXT);
  assign start     = accept && is_ctrl && trig_high && !prev_high_r && (neff != '0);

  assign in_stall  = (state_r != S_IDLE);
  assign idx       = idx_r;

  always_comb begin
    cmd = '0;
    cmd.axis = AX_X;
    unique case (state_r)
      S_IDLE: begin
        cmd.wr_en  = accept && !is_ctrl && slot_ok;
        cmd.loc_ld = start;
      end
      S_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_SQ: begin
        cmd.diff_en = (step_r != SQ_LAST);
        cmd.acc_en  = (step_r != '0);
        if (step_r != SQ_LAST) begin
          cmd.axis = axis_t'(step_r[1:0]);
        end
      end
      S_ROOT: begin
        cmd.root_init = (step_r == '0);
        cmd.root_step = (step_r != '0);
      end
      S_EMIT: begin
        cmd.out_ld   = !out_hold;
        cmd.out_last = (idx_r == last_r);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      last_r      <= '0;
      step_r      <= '0;
      prev_high_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && is_ctrl) begin
            prev_high_r <= trig_high;
          end
          if (start) begin
            idx_r   <= '0;
            last_r  <= IDX_W'(neff - CMP_W'(1));
            state_r <= S_READ;
          end
        end
        S_READ: begin
          step_r  <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (step_r == SQ_LAST) begin
            step_r  <= '0;
            state_r <= S_ROOT;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_ROOT: begin
          if (step_r == RT_LAST) begin
            step_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_EMIT: begin
          if (!out_hold) begin
            if (idx_r == last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/tdt_dp.sv
// Datapath of the triggered distance table unit: coordinate memory, squarer, root, result word.
module tdt_dp #(
  parameter int MAX_COORDS = 64,
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tdt_pkg::dp_cmd_t                  cmd,
  input  logic [IDX_W-1:0]                  idx,
  input  logic [tdt_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [COORD_BITS-1:0]      in_pos_x,
  input  logic signed [COORD_BITS-1:0]      in_pos_y,
  input  logic signed [COORD_BITS-1:0]      in_pos_z,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [tdt_pkg::SLOT_W-1:0]        out_slot_out,
  output logic [COORD_BITS:0]               out_distance,
  output logic                              out_last,
  output logic                              out_hold
);
  import tdt_pkg::*;

  localparam int CRD_W  = 3 * COORD_BITS;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int DIST_W = COORD_BITS + 1;
  localparam logic [SUM_W-1:0] ROOT_TOP = SUM_W'(1) << (SUM_W - 2);

  logic [CRD_W-1:0]              mem_r [MAX_COORDS];
  logic [MAX_COORDS-1:0]         vld_r;
  logic [CRD_W-1:0]              crd_r;
  logic                          crd_vld_r;
  logic [CRD_W-1:0]              crd;

  logic signed [COORD_BITS-1:0]  loc_x_r, loc_y_r, loc_z_r;
  logic signed [COORD_BITS-1:0]  op_a, op_b;
  logic signed [DIFF_W-1:0]      diff;
  logic [COORD_BITS-1:0]         mag;
  logic [COORD_BITS-1:0]         mag_r;
  logic [SQ_W-1:0]               sq;
  logic [SUM_W-1:0]              acc_r;

  logic [SUM_W-1:0]              rem_r, res_r, bit_r;
  logic [SUM_W-1:0]              trial;

  logic                          out_valid_r;
  logic [SLOT_W-1:0]             out_slot_r;
  logic [DIST_W-1:0]             out_dist_r;
  logic                          out_last_r;

  // Coordinate memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[IDX_W'(in_slot)] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    if (cmd.rd_en) begin
      crd_r <= mem_r[idx];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      crd_vld_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[IDX_W'(in_slot)] <= 1'b1;
      end
      if (cmd.rd_en) begin
        crd_vld_r <= vld_r[idx];
      end
    end
  end

  assign crd = crd_vld_r ? crd_r : '0;

  always_comb begin
    unique case (cmd.axis)
      AX_X: begin
        op_a = loc_x_r;
        op_b = crd[COORD_BITS-1:0];
      end
      AX_Y: begin
        op_a = loc_y_r;
        op_b = crd[2*COORD_BITS-1:COORD_BITS];
      end
      AX_Z: begin
        op_a = loc_z_r;
        op_b = crd[CRD_W-1:2*COORD_BITS];
      end
      default: begin
        op_a = loc_x_r;
        op_b = crd[COORD_BITS-1:0];
      end
    endcase
  end

  assign diff  = DIFF_W'(op_a) - DIFF_W'(op_b);
  assign mag   = diff[DIFF_W-1] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
  assign sq    = SQ_W'(mag_r) * SQ_W'(mag_r);
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.loc_ld) begin
      loc_x_r <= in_pos_x;
      loc_y_r <= in_pos_y;
      loc_z_r <= in_pos_z;
    end
    if (cmd.diff_en) begin
      mag_r <= mag;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + SUM_W'(sq);
    end
    // Square root, one result digit per step.
    if (cmd.root_init) begin
      rem_r <= acc_r;
      res_r <= '0;
      bit_r <= ROOT_TOP;
    end else if (cmd.root_step) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign out_hold = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_slot_r <= SLOT_W'(idx);
      out_dist_r <= res_r[DIST_W-1:0];
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_slot_out = out_slot_r;
  assign out_distance = out_dist_r;
  assign out_last     = out_last_r;

endmodule

// File: hw/rtl/triggered_distance_table_unit.sv
// Top level of the triggered distance table unit: register port, sequencer and datapath.
//
// Input channel (in_valid / in_stall): each word is either a load (in_action 0) that
// writes in_pos_x/y/z into table entry in_slot, or a control word (in_action 1) with a
// trigger level and a listener location. A control word whose trigger is above zero
// while the previous control trigger was not starts a run: for each of the first
// coord_count entries the unit emits the floor distance from the location, in Q9.8.
// Output channel (out_valid / out_stall): one word per entry, in slot order, out_last
// high on the final word of the run.
// Timing: a load or a control word without an edge is taken whenever the unit is idle.
// A run treats the entries in turn: one memory read, each axis in turn through the
// shared squarer and accumulator, the digit-by-digit square root and a load of the
// result register. in_stall stays high for the whole run.
// The result register lets the run finish while its last word waits.
// A stalled receiver holds the result register and the sequencer waits for it.
// Reset (rst_n, synchronous) empties the table (every entry reads as zero), clears the
// trigger history, drops any pending result and sets coord_count to 64.
// Register at byte address 0: coord_count, 7 bits; values above the table size act as
// the table size, zero makes a trigger edge produce nothing.
module triggered_distance_table_unit #(
  parameter int MAX_COORDS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tdt_pkg::APB_AW-1:0]        paddr,
  input  logic [tdt_pkg::APB_DW-1:0]        pwdata,
  output logic [tdt_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [tdt_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [COORD_BITS-1:0]      in_pos_x,
  input  logic signed [COORD_BITS-1:0]      in_pos_y,
  input  logic signed [COORD_BITS-1:0]      in_pos_z,
  input  logic signed [tdt_pkg::TRIG_W-1:0] in_trigger,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tdt_pkg::SLOT_W-1:0]        out_slot_out,
  output logic [COORD_BITS:0]               out_distance,
  output logic                              out_last
);
  import tdt_pkg::*;

  localparam int IDX_W = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;

  logic [CNT_W-1:0] count_r;
  logic             cfg_wr;
  logic             out_hold;
  logic [IDX_W-1:0] idx;
  dp_cmd_t          cmd;

  // Register port: no wait states, write on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_COUNT);
  assign prdata = (paddr == ADDR_COUNT) ? APB_DW'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RST;
    end else if (cfg_wr) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  tdt_ctrl #(
    .MAX_COORDS (MAX_COORDS),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (in_action),
    .in_slot     (in_slot),
    .in_trigger  (in_trigger),
    .coord_count (count_r),
    .out_hold    (out_hold),
    .in_stall    (in_stall),
    .idx         (idx),
    .cmd         (cmd)
  );

  tdt_dp #(
    .MAX_COORDS (MAX_COORDS),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .idx          (idx),
    .in_slot      (in_slot),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_slot_out (out_slot_out),
    .out_distance (out_distance),
    .out_last     (out_last),
    .out_hold     (out_hold)
  );

  // A word that does not close the run leaves the unit still busy with that run.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |-> in_stall)
    else $error("non-final result taken while the input side is open");

  // Results only appear out of a run.
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(rst_n) |-> $past(in_stall))
    else $error("result word appeared outside a run");

  // The end of a run leaves its final word in the result register.
  a_run_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) && $past(rst_n) |-> out_valid && out_last)
    else $error("run ended without a final result word");

endmodule

// File: tb/triggered_distance_table_unit_test.sv
// Self-checking testbench for the triggered distance table unit: random words, shadow predictor.
module triggered_distance_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdt_pkg::*;

  // Run length guard: worst case is every control word an edge at 64 entries, every
  // result waiting out the longest receiver stall, taken several times over.
  localparam int LIMIT_CYCLES   = 3_000_000;
  // Cycles to let pass once idle: too few for a full run of 64 entries, but only
  // loads and edgeless controls can be in flight when nothing is expected.
  localparam int SETTLE_CYCLES  = 64;
  localparam int LONG_HOLD      = 400;
  localparam int BURSTS_PER_SET = 6;
  localparam int TABLE_SIZE     = 64;

  typedef struct {
    action_t            action;
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] trig;
  } word_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [16:0]       distance;
    logic              last;
  } dist_word_t;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               in_action  = 1'b0;
  logic [SLOT_W-1:0]  in_slot    = '0;
  logic signed [15:0] in_pos_x   = '0;
  logic signed [15:0] in_pos_y   = '0;
  logic signed [15:0] in_pos_z   = '0;
  logic signed [15:0] in_trigger = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] out_slot_out;
  logic [16:0]       out_distance;
  logic              out_last;

  triggered_distance_table_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_slot      (in_slot),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_trigger   (in_trigger),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot_out (out_slot_out),
    .out_distance (out_distance),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  // Words waiting for the driver, and distances the unit still owes us.
  word_t      pending_words[$];
  dist_word_t dist_due[$];

  // Shadow of the unit: coordinate table, trigger history and the count register.
  logic signed [15:0] coord_x [TABLE_SIZE];
  logic signed [15:0] coord_y [TABLE_SIZE];
  logic signed [15:0] coord_z [TABLE_SIZE];
  logic               trig_was_high;
  logic [CNT_W-1:0]   count_shadow = COUNT_RST;

  int  mismatches = 0;
  int  cycle_count = 0;
  // Raised once by the stimulus to make the receiver hold off for a long stretch.
  logic hold_request = 1'b0;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Floor of the Euclidean distance in Q9.8: the floor of the integer root of the Q18.16
  // sum of squares. Build the root one bit at a time from the top.
  function automatic logic [16:0] floor_dist(input logic signed [15:0] ax, ay, az,
                                             input logic signed [15:0] bx, by, bz);
    longint dx, dy, dz;
    longint unsigned sum_sq, root, cand;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    sum_sq = longint'(dx * dx + dy * dy + dz * dz);
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= sum_sq) root = cand;
    end
    return root[16:0];
  endfunction

  // Apply one accepted word to the shadow; a rising trigger queues a whole run.
  task automatic apply_word(input word_t w);
    int         n;
    dist_word_t d;
    if (w.action == ACT_LOAD) begin
      coord_x[w.slot] = w.x;
      coord_y[w.slot] = w.y;
      coord_z[w.slot] = w.z;
    end else begin
      if (w.trig > 0 && !trig_was_high) begin
        n = (count_shadow > CNT_W'(TABLE_SIZE)) ? TABLE_SIZE : int'(count_shadow);
        for (int i = 0; i < n; i++) begin
          d.slot = SLOT_W'(i);
          d.distance = floor_dist(w.x, w.y, w.z, coord_x[i], coord_y[i], coord_z[i]);
          d.last = (i == n - 1);
          dist_due.push_back(d);
        end
      end
      trig_was_high = (w.trig > 0);
    end
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: hold the word while stalled, advance on acceptance or when idle.
  always @(posedge clk) begin : drive_words
    static word_t on_bus;
    static int    gap_left = 0;
    word_t        w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      trig_was_high = 1'b0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        coord_x[i] = '0;
        coord_y[i] = '0;
        coord_z[i] = '0;
      end
    end else begin
      if (in_valid && !in_stall) apply_word(on_bus);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          on_bus = w;
          in_valid   <= 1'b1;
          in_action  <= w.action;
          in_slot    <= w.slot;
          in_pos_x   <= w.x;
          in_pos_y   <= w.y;
          in_pos_z   <= w.z;
          in_trigger <= w.trig;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver: check every accepted word against the oldest
  // expectation, then pick the next stall level.
  always @(posedge clk) begin : take_results
    static int  stall_left = 0;
    static int  hold_left  = 0;
    static bit  hold_taken = 1'b0;
    dist_word_t d;
    int         r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dist_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word slot %0d distance %0d last %0b",
                                    out_slot_out, out_distance, out_last));
        end else begin
          d = dist_due.pop_front();
          if (out_slot_out !== d.slot)
            report_mismatch($sformatf("slot_out %0d, want %0d", out_slot_out, d.slot));
          if (out_distance !== d.distance)
            report_mismatch($sformatf("distance %0d at slot %0d, want %0d",
                                      out_distance, d.slot, d.distance));
          if (out_last !== d.last)
            report_mismatch($sformatf("last %0b at slot %0d, want %0b",
                                      out_last, d.slot, d.last));
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_request && !hold_taken) begin
        // Hold off long enough that the result register fills and the input stalls.
        out_stall <= 1'b1;
        hold_left = LONG_HOLD;
        hold_taken = 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(10, 50);
        end
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("triggered_distance_table_unit test failed");
      $finish;
    end
  end

  function automatic void queue_word(input action_t act, input int slot,
                                     input logic signed [15:0] x, y, z, trig);
    word_t w;
    w.action = act;
    w.slot   = SLOT_W'(slot);
    w.x      = x;
    w.y      = y;
    w.z      = z;
    w.trig   = trig;
    pending_words.push_back(w);
  endfunction

  // Coordinates: extremes, a band near the origin, or anything at all.
  function automatic logic signed [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 5) return 16'($urandom_range(0, 2048) - 1024);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] low_trig();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'sh0000;
    if (r == 1) return 16'sh8000;
    return 16'sh8000 | 16'($urandom);
  endfunction

  function automatic logic signed [15:0] high_trig();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'sh0001;
    if (r == 1) return 16'sh7FFF;
    return 16'($urandom_range(1, 32767));
  endfunction

  // Most loads land in the active part of the table so that runs see them.
  function automatic int pick_slot();
    int active;
    active = (count_shadow > CNT_W'(TABLE_SIZE)) ? TABLE_SIZE : int'(count_shadow);
    if (active == 0 || $urandom_range(0, 9) < 3) return $urandom_range(0, TABLE_SIZE - 1);
    return $urandom_range(0, active - 1);
  endfunction

  // One burst: a few loads, then usually a low/high control pair for a clean edge,
  // sometimes a lone control that may or may not give an edge.
  task automatic queue_burst();
    int kind;
    @(negedge clk);
    repeat ($urandom_range(0, 3))
      queue_word(ACT_LOAD, pick_slot(), rand_coord(), rand_coord(), rand_coord(),
                 16'($urandom));
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      queue_word(ACT_CTRL, $urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord(),
                 low_trig());
      queue_word(ACT_CTRL, $urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord(),
                 high_trig());
    end else begin
      queue_word(ACT_CTRL, $urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord(),
                 (kind < 9) ? high_trig() : low_trig());
    end
  endtask

  // Block until every word went in and every distance came out, then settle.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || dist_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write coord_count, then read it back.
  task automatic write_count(input logic [CNT_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_COUNT;
    pwdata  <= {{(APB_DW - CNT_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_shadow = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CNT_W-1:0] !== value)
      report_mismatch($sformatf("coord_count reads %0d, want %0d", prdata[CNT_W-1:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_setting(input logic [CNT_W-1:0] count);
    write_count(count);
    if (count > CNT_W'(TABLE_SIZE)) begin
      // Force an edge up front so the long hold meets a full run.
      @(negedge clk);
      hold_request = 1'b1;
      queue_word(ACT_CTRL, 0, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh8000);
      queue_word(ACT_CTRL, 0, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh0100);
    end
    repeat (BURSTS_PER_SET) begin
      queue_burst();
      // Now and then let the unit drain completely before going on.
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset count of 64.
    // Edge against the empty table: every slot is at distance from the origin.
    queue_word(ACT_CTRL, 0, 16'sh0100, 16'shFE00, 16'sh0300, 16'sh0100);
    // Still high: no edge.
    queue_word(ACT_CTRL, 5, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF);
    // Loads at the field extremes, one into the top slot.
    queue_word(ACT_LOAD, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0100);
    queue_word(ACT_LOAD, 1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_word(ACT_LOAD, 63, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);
    queue_word(ACT_LOAD, 2, 16'sh0001, 16'shFFFF, 16'sh0000, 16'sh7FFF);
    // Zero trigger counts as low.
    queue_word(ACT_CTRL, 0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    // Smallest positive trigger at the far corner: largest distance at slot 0.
    queue_word(ACT_CTRL, 63, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0001);
    queue_word(ACT_CTRL, 0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000);
    queue_word(ACT_CTRL, 0, 16'sh0000, 16'sh0000, 16'sh0000, 16'shFFFF);
    queue_word(ACT_CTRL, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    // A load while high leaves the trigger history alone: the next high gives no run.
    queue_word(ACT_LOAD, 63, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh8000);
    queue_word(ACT_CTRL, 0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100);
    queue_word(ACT_CTRL, 0, 16'sh0000, 16'sh0000, 16'sh0000, 16'shFF00);
    queue_word(ACT_CTRL, 0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF);
    wait_drained();

    // Random part over several counts: one, zero, above the table, small, full, two, one short of full.
    run_setting(7'd1);
    run_setting(7'd0);
    run_setting(7'd127);
    run_setting(7'd5);
    run_setting(7'd64);
    run_setting(7'd2);
    run_setting(7'(TABLE_SIZE - 1));

    wait_drained();
    if (mismatches == 0) begin
      $display("triggered_distance_table_unit test passed");
    end else begin
      $display("triggered_distance_table_unit test failed");
    end
    $finish;
  end

endmodule
